>>> rtl/core/etp_pkg.sv
// Shared types, character codes and helper functions of the endpoint text parser.
package etp_pkg;

  typedef enum logic [2:0] {
    HexWs     = 3'd0,
    HexSign   = 3'd1,
    HexZero   = 3'd2,
    HexPrefix = 3'd3,
    HexDigits = 3'd4
  } hex_phase_e;

  typedef enum logic [1:0] {
    DecWs     = 2'd0,
    DecSign   = 2'd1,
    DecDigits = 2'd2
  } dec_phase_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  localparam logic [3:0]  HexBytes     = 4'd12;
  localparam logic [3:0]  HexAddrLast  = 4'd7;
  localparam logic [3:0]  HexPortLast  = 4'd11;
  localparam logic [3:0]  HexAddrBytes = 4'd8;
  localparam logic [1:0]  DotsNeeded   = 2'd3;
  localparam logic [1:0]  ColonMax     = 2'd2;
  localparam logic [16:0] DecSat       = 17'd65536;
  localparam logic [16:0] OctetMax     = 17'd255;
  localparam logic [16:0] PortMax      = 17'd65535;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic hex_digit_t hex_val(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/endpoint_text_parser_top.sv
// Endpoint text parser: byte-serial IPv4 dotted-quad and port, or hex address and port.
// The block takes one byte of endpoint text per cycle, one transaction per cycle, while no
// last byte waits on the result register. Each accepted byte is held in an input register
// and from there updates the parser state; a byte flagged last also loads the result
// register, after the input register. Only a last byte waits on the result register, and the
// input keeps accepting while a result is held, since only the next last byte needs the
// result register to be free or being taken.
module endpoint_text_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [31:0] address_o,
  output logic [15:0] port_o,
  output logic        format_o
);

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       advance;
  logic       out_valid_q;

  logic [1:0]            colon_count_q, colon_count_d;
  logic [3:0]            byte_pos_q, byte_pos_d;
  etp_pkg::hex_phase_e   hex_phase_q, hex_phase_d;
  logic [31:0]           hex_addr_q, hex_addr_d;
  logic [15:0]           hex_port_q, hex_port_d;
  logic                  hex_neg_q, hex_neg_d;
  logic                  hex_fail_q, hex_fail_d;
  logic [1:0]            dot_count_q, dot_count_d;
  etp_pkg::dec_phase_e   dec_phase_q, dec_phase_d;
  logic [16:0]           dec_value_q, dec_value_d;
  logic                  dec_neg_q, dec_neg_d;
  logic                  dec_fail_q, dec_fail_d;
  logic [31:0]           ip_q, ip_d;

  logic                  res_ok;
  logic [31:0]           res_addr;
  logic [15:0]           res_port;
  etp_pkg::hex_digit_t   hd;
  logic                  hex_acc;
  logic [31:0]           hex_v;
  logic                  dec_acc;
  logic [19:0]           dec_mul;
  logic                  field_ok_octet;

  assign advance     = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    hd          = etp_pkg::hex_val(ch_q);
    hex_phase_d = hex_phase_q;
    hex_addr_d  = hex_addr_q;
    hex_port_d  = hex_port_q;
    hex_neg_d   = hex_neg_q;
    hex_fail_d  = hex_fail_q;
    byte_pos_d  = byte_pos_q;
    hex_acc     = 1'b0;
    hex_v       = 32'd0;
    if (byte_pos_q < etp_pkg::HexBytes) begin
      byte_pos_d = byte_pos_q + 4'd1;
      unique case (hex_phase_q)
        etp_pkg::HexWs: begin
          if (etp_pkg::is_ws(ch_q)) begin
            hex_acc = 1'b0;
          end else if (ch_q == etp_pkg::ChPlus || ch_q == etp_pkg::ChMinus) begin
            hex_phase_d = etp_pkg::HexSign;
            hex_neg_d   = (ch_q == etp_pkg::ChMinus);
          end else if (ch_q == etp_pkg::ChZero) begin
            hex_phase_d = etp_pkg::HexZero;
          end else begin
            hex_acc = 1'b1;
          end
        end
        etp_pkg::HexSign: begin
          if (ch_q == etp_pkg::ChZero) begin
            hex_phase_d = etp_pkg::HexZero;
          end else begin
            hex_acc = 1'b1;
          end
        end
        etp_pkg::HexZero: begin
          if (ch_q == etp_pkg::ChLowX || ch_q == etp_pkg::ChUpX) begin
            hex_phase_d = etp_pkg::HexPrefix;
          end else begin
            hex_acc = 1'b1;
          end
        end
        default: begin
          hex_acc = 1'b1;
        end
      endcase
      if (hex_acc) begin
        if (hd.ok) begin
          if (byte_pos_q < etp_pkg::HexAddrBytes) begin
            hex_addr_d = {hex_addr_q[27:0], hd.value};
          end else begin
            hex_port_d = {hex_port_q[11:0], hd.value};
          end
          hex_phase_d = etp_pkg::HexDigits;
        end else begin
          hex_fail_d = 1'b1;
        end
      end
      if (byte_pos_q == etp_pkg::HexAddrLast || byte_pos_q == etp_pkg::HexPortLast) begin
        hex_v = (byte_pos_q == etp_pkg::HexAddrLast) ? hex_addr_d : {16'd0, hex_port_d};
        if (!(hex_phase_d == etp_pkg::HexZero || hex_phase_d == etp_pkg::HexDigits) ||
            (hex_neg_d && hex_v != 32'd0)) begin
          hex_fail_d = 1'b1;
        end
        hex_phase_d = etp_pkg::HexWs;
        hex_neg_d   = 1'b0;
      end
    end
  end

  always_comb begin
    colon_count_d  = colon_count_q;
    dot_count_d    = dot_count_q;
    dec_phase_d    = dec_phase_q;
    dec_value_d    = dec_value_q;
    dec_neg_d      = dec_neg_q;
    dec_fail_d     = dec_fail_q;
    ip_d           = ip_q;
    dec_acc        = 1'b0;
    dec_mul        = ({3'd0, dec_value_q} << 3) + ({3'd0, dec_value_q} << 1) +
                     {16'd0, ch_q[3:0]};
    field_ok_octet = (dec_phase_q == etp_pkg::DecDigits) &&
                     (dec_value_q <= etp_pkg::OctetMax) &&
                     !(dec_neg_q && dec_value_q != 17'd0);
    if (ch_q == etp_pkg::ChColon) begin
      if (colon_count_q == 2'd0) begin
        if (dot_count_q != etp_pkg::DotsNeeded || !field_ok_octet) begin
          dec_fail_d = 1'b1;
        end else begin
          ip_d = ip_q | {dec_value_q[7:0], 24'd0};
        end
        dec_phase_d = etp_pkg::DecWs;
        dec_value_d = 17'd0;
        dec_neg_d   = 1'b0;
      end
      if (colon_count_q < etp_pkg::ColonMax) begin
        colon_count_d = colon_count_q + 2'd1;
      end
    end else if (ch_q == etp_pkg::ChDot && colon_count_q == 2'd0) begin
      if (dot_count_q >= etp_pkg::DotsNeeded || !field_ok_octet) begin
        dec_fail_d = 1'b1;
      end else begin
        ip_d        = ip_q | ({24'd0, dec_value_q[7:0]} << {dot_count_q, 3'd0});
        dot_count_d = dot_count_q + 2'd1;
      end
      dec_phase_d = etp_pkg::DecWs;
      dec_value_d = 17'd0;
      dec_neg_d   = 1'b0;
    end else begin
      unique case (dec_phase_q)
        etp_pkg::DecWs: begin
          if (etp_pkg::is_ws(ch_q)) begin
            dec_acc = 1'b0;
          end else if (ch_q == etp_pkg::ChPlus || ch_q == etp_pkg::ChMinus) begin
            dec_phase_d = etp_pkg::DecSign;
            dec_neg_d   = (ch_q == etp_pkg::ChMinus);
          end else begin
            dec_acc = 1'b1;
          end
        end
        default: begin
          dec_acc = 1'b1;
        end
      endcase
      if (dec_acc) begin
        if (!etp_pkg::is_dec(ch_q)) begin
          dec_fail_d = 1'b1;
        end else begin
          dec_value_d = (dec_mul > {3'd0, etp_pkg::DecSat}) ? etp_pkg::DecSat : dec_mul[16:0];
          dec_phase_d = etp_pkg::DecDigits;
        end
      end
    end
  end

  always_comb begin
    res_ok   = 1'b0;
    res_addr = 32'd0;
    res_port = 16'd0;
    if (colon_count_d == 2'd1) begin
      if (!dec_fail_d && dec_phase_d == etp_pkg::DecDigits &&
          dec_value_d <= etp_pkg::PortMax && !(dec_neg_d && dec_value_d != 17'd0)) begin
        res_ok   = 1'b1;
        res_addr = ip_d;
        res_port = dec_value_d[15:0];
      end
    end else if (colon_count_d == 2'd0) begin
      if (byte_pos_d >= etp_pkg::HexBytes && !hex_fail_d) begin
        res_ok   = 1'b1;
        res_addr = hex_addr_d;
        res_port = hex_port_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_count_q <= 2'd0;
      byte_pos_q    <= 4'd0;
      hex_phase_q   <= etp_pkg::HexWs;
      hex_addr_q    <= 32'd0;
      hex_port_q    <= 16'd0;
      hex_neg_q     <= 1'b0;
      hex_fail_q    <= 1'b0;
      dot_count_q   <= 2'd0;
      dec_phase_q   <= etp_pkg::DecWs;
      dec_value_q   <= 17'd0;
      dec_neg_q     <= 1'b0;
      dec_fail_q    <= 1'b0;
      ip_q          <= 32'd0;
    end else if (advance) begin
      if (last_q) begin
        colon_count_q <= 2'd0;
        byte_pos_q    <= 4'd0;
        hex_phase_q   <= etp_pkg::HexWs;
        hex_addr_q    <= 32'd0;
        hex_port_q    <= 16'd0;
        hex_neg_q     <= 1'b0;
        hex_fail_q    <= 1'b0;
        dot_count_q   <= 2'd0;
        dec_phase_q   <= etp_pkg::DecWs;
        dec_value_q   <= 17'd0;
        dec_neg_q     <= 1'b0;
        dec_fail_q    <= 1'b0;
        ip_q          <= 32'd0;
      end else begin
        colon_count_q <= colon_count_d;
        byte_pos_q    <= byte_pos_d;
        hex_phase_q   <= hex_phase_d;
        hex_addr_q    <= hex_addr_d;
        hex_port_q    <= hex_port_d;
        hex_neg_q     <= hex_neg_d;
        hex_fail_q    <= hex_fail_d;
        dot_count_q   <= dot_count_d;
        dec_phase_q   <= dec_phase_d;
        dec_value_q   <= dec_value_d;
        dec_neg_q     <= dec_neg_d;
        dec_fail_q    <= dec_fail_d;
        ip_q          <= ip_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      valid_res_o <= res_ok;
      address_o   <= res_addr;
      port_o      <= res_port;
      format_o    <= (colon_count_d != 2'd0);
    end
  end

  // The parser state is cleared after every final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> byte_pos_q == 4'd0 && colon_count_q == 2'd0 && !dec_fail_q)
    else $error("parser state not cleared after final byte");

  // A rejected string carries a zero address and port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> address_o == 32'd0 && port_o == 16'd0)
    else $error("rejected result carries nonzero payload");

  // Saturating counters never run past their limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q <= etp_pkg::HexBytes && colon_count_q <= etp_pkg::ColonMax &&
    dec_value_q <= etp_pkg::DecSat)
    else $error("saturating counter out of range");

  // A held result is not overwritten by the next final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(advance && last_q))
    else $error("result register overwritten while held");

endmodule
